### hdl/ami_pkg.sv
package ami_pkg;

  localparam int ElemW = 32;
  localparam int FracB = 16;
  localparam int NElem = 12;
  localparam int NTerm = 6;
  localparam int NLane = 4;
  localparam int RowW  = 2;
  localparam int IdxW  = 4;

  localparam int ProdW = 2 * ElemW;
  localparam int CofW  = 2 * ElemW + 1;
  localparam int TripW = 3 * ElemW;
  localparam int DiffW = 3 * ElemW + 1;
  localparam int DetW  = 3 * ElemW + 3;
  localparam int NumW  = 3 * ElemW + FracB + 4;
  localparam int QuoW  = ElemW;

  localparam logic [RowW-1:0] Row0 = 2'd0;
  localparam logic [RowW-1:0] Row1 = 2'd1;
  localparam logic [RowW-1:0] Row2 = 2'd2;

  localparam logic [ElemW-1:0] FixOne = ElemW'(1) << FracB;
  localparam logic [ElemW-1:0] SatMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] SatMin = {1'b1, {(ElemW-1){1'b0}}};

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [IdxW-1:0] idx_t;

  // Determinant: first three terms add, last three subtract.
  localparam idx_t DetTab [NTerm][3] = '{
    '{4'd0, 4'd5, 4'd10}, '{4'd1, 4'd6, 4'd8}, '{4'd2, 4'd4, 4'd9},
    '{4'd0, 4'd6, 4'd9},  '{4'd1, 4'd4, 4'd10}, '{4'd2, 4'd5, 4'd8}
  };

  // Translation cofactors per output row, same sign pattern.
  localparam idx_t TrTab [3][NTerm][3] = '{
    '{'{4'd1, 4'd7, 4'd10}, '{4'd2, 4'd5, 4'd11}, '{4'd3, 4'd6, 4'd9},
      '{4'd1, 4'd6, 4'd11}, '{4'd2, 4'd7, 4'd9},  '{4'd3, 4'd5, 4'd10}},
    '{'{4'd0, 4'd6, 4'd11}, '{4'd2, 4'd7, 4'd8},  '{4'd3, 4'd4, 4'd10},
      '{4'd0, 4'd7, 4'd10}, '{4'd2, 4'd4, 4'd11}, '{4'd3, 4'd6, 4'd8}},
    '{'{4'd0, 4'd7, 4'd9},  '{4'd1, 4'd4, 4'd11}, '{4'd3, 4'd5, 4'd8},
      '{4'd0, 4'd5, 4'd11}, '{4'd1, 4'd7, 4'd8},  '{4'd3, 4'd4, 4'd9}}
  };

  // 2x2 cofactors: e[a]*e[b] - e[c]*e[d].
  localparam idx_t CofTab [3][3][4] = '{
    '{'{4'd5, 4'd10, 4'd6, 4'd9}, '{4'd2, 4'd9, 4'd1, 4'd10}, '{4'd1, 4'd6, 4'd2, 4'd5}},
    '{'{4'd6, 4'd8, 4'd4, 4'd10}, '{4'd0, 4'd10, 4'd2, 4'd8}, '{4'd2, 4'd4, 4'd0, 4'd6}},
    '{'{4'd4, 4'd9, 4'd5, 4'd8},  '{4'd1, 4'd8, 4'd0, 4'd9},  '{4'd0, 4'd5, 4'd1, 4'd4}}
  };

endpackage

### hdl/affine_matrix_inverse.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-------------------------------
// matrix   | m00..m23                                | beat taken when start && !busy
// result   | row_index, col0..col3, singular, last_row | one beat per cycle with valid
//
// A new matrix can be taken once the previous one reaches its last row: the row
// sequencer feeds one row of the inverse per cycle into the pipeline, and busy is
// high while rows 0 and 1 issue. Each row passes through 5 multiply/add stages, 2
// divide setup stages, 32 restoring divide stages (one quotient bit each) and the
// output register, so the three rows of a matrix come out in order, one per cycle.
// rst is synchronous and clears the sequencer and all stage valid bits; the receiver
// cannot stall, so nothing in the pipeline ever holds.
module affine_matrix_inverse (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ami_pkg::elem_t m00,
  input  ami_pkg::elem_t m01,
  input  ami_pkg::elem_t m02,
  input  ami_pkg::elem_t m03,
  input  ami_pkg::elem_t m10,
  input  ami_pkg::elem_t m11,
  input  ami_pkg::elem_t m12,
  input  ami_pkg::elem_t m13,
  input  ami_pkg::elem_t m20,
  input  ami_pkg::elem_t m21,
  input  ami_pkg::elem_t m22,
  input  ami_pkg::elem_t m23,
  output logic valid,
  output logic [ami_pkg::RowW-1:0] row_index,
  output ami_pkg::elem_t col0,
  output ami_pkg::elem_t col1,
  output ami_pkg::elem_t col2,
  output ami_pkg::elem_t col3,
  output logic singular,
  output logic last_row
);
  import ami_pkg::*;

  // Row sequencer. The accepted matrix is held while its three rows issue.
  elem_t mat [NElem];
  logic seq_active;
  logic [RowW-1:0] seq_row;

  assign busy = seq_active && (seq_row != Row2);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_row <= Row0;
    end else if (start && !busy) begin
      seq_active <= 1'b1;
      seq_row <= Row0;
    end else if (seq_active) begin
      seq_active <= (seq_row != Row2);
      seq_row <= (seq_row == Row2) ? Row0 : seq_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mat <= '{m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23};
    end
  end

  // Stage 1: pair products. The determinant is recomputed for every row, which
  // keeps each row self-contained in the pipeline.
  logic s1_valid;
  logic [RowW-1:0] s1_row;
  logic signed [ProdW-1:0] s1_dab [NTerm];
  logic signed [ProdW-1:0] s1_tab [NTerm];
  logic signed [ProdW-1:0] s1_cp [3][2];
  elem_t s1_dc [NTerm];
  elem_t s1_tc [NTerm];

  // Stage 2: the 64 x 32 triple products split into two 32-bit halves, and the 2x2 cofactors.
  logic s2_valid;
  logic [RowW-1:0] s2_row;
  logic signed [ProdW-1:0] s2_dhi [NTerm];
  logic signed [ProdW-1:0] s2_thi [NTerm];
  logic signed [CofW-1:0] s2_dlo [NTerm];
  logic signed [CofW-1:0] s2_tlo [NTerm];
  logic signed [CofW-1:0] s2_cof [3];

  // Stage 3: whole triple products.
  logic s3_valid;
  logic [RowW-1:0] s3_row;
  logic signed [TripW-1:0] s3_dt [NTerm];
  logic signed [TripW-1:0] s3_tt [NTerm];
  logic signed [CofW-1:0] s3_cof [3];

  // Stage 4: positive minus negative terms, pairwise.
  logic s4_valid;
  logic [RowW-1:0] s4_row;
  logic signed [DiffW-1:0] s4_du [3];
  logic signed [DiffW-1:0] s4_tu [3];
  logic signed [CofW-1:0] s4_cof [3];

  // Stage 5: determinant and translation cofactor.
  logic s5_valid;
  logic [RowW-1:0] s5_row;
  logic signed [DetW-1:0] s5_det;
  logic signed [DetW-1:0] s5_tsum;
  logic signed [CofW-1:0] s5_cof [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NTerm; k++) begin
      s1_dab[k] <= mat[DetTab[k][0]] * mat[DetTab[k][1]];
      s1_dc[k] <= mat[DetTab[k][2]];
      s1_tab[k] <= mat[TrTab[seq_row][k][0]] * mat[TrTab[seq_row][k][1]];
      s1_tc[k] <= mat[TrTab[seq_row][k][2]];
    end
    for (int c = 0; c < 3; c++) begin
      s1_cp[c][0] <= mat[CofTab[seq_row][c][0]] * mat[CofTab[seq_row][c][1]];
      s1_cp[c][1] <= mat[CofTab[seq_row][c][2]] * mat[CofTab[seq_row][c][3]];
    end
    s1_row <= seq_row;

    for (int k = 0; k < NTerm; k++) begin
      s2_dhi[k] <= $signed(s1_dab[k][ProdW-1:ElemW]) * s1_dc[k];
      s2_dlo[k] <= $signed({1'b0, s1_dab[k][ElemW-1:0]}) * s1_dc[k];
      s2_thi[k] <= $signed(s1_tab[k][ProdW-1:ElemW]) * s1_tc[k];
      s2_tlo[k] <= $signed({1'b0, s1_tab[k][ElemW-1:0]}) * s1_tc[k];
    end
    for (int c = 0; c < 3; c++) begin
      s2_cof[c] <= CofW'(s1_cp[c][0]) - CofW'(s1_cp[c][1]);
    end
    s2_row <= s1_row;

    for (int k = 0; k < NTerm; k++) begin
      s3_dt[k] <= (TripW'(s2_dhi[k]) <<< ElemW) + TripW'(s2_dlo[k]);
      s3_tt[k] <= (TripW'(s2_thi[k]) <<< ElemW) + TripW'(s2_tlo[k]);
    end
    s3_cof <= s2_cof;
    s3_row <= s2_row;

    for (int k = 0; k < 3; k++) begin
      s4_du[k] <= DiffW'(s3_dt[k]) - DiffW'(s3_dt[k+3]);
      s4_tu[k] <= DiffW'(s3_tt[k]) - DiffW'(s3_tt[k+3]);
    end
    s4_cof <= s3_cof;
    s4_row <= s3_row;

    s5_det <= DetW'(s4_du[0]) + DetW'(s4_du[1]) + DetW'(s4_du[2]);
    s5_tsum <= DetW'(s4_tu[0]) + DetW'(s4_tu[1]) + DetW'(s4_tu[2]);
    s5_cof <= s4_cof;
    s5_row <= s4_row;
  end

  // Stage 6: magnitudes and signs. Lanes 0..2 are the linear columns (scaled by
  // two fraction widths), lane 3 is the translation (scaled by one).
  logic signed [NumW-1:0] num [NLane];
  logic s6_valid;
  logic [RowW-1:0] s6_row;
  logic s6_sing;
  logic s6_dneg;
  logic [DetW-1:0] s6_dmag;
  logic [NumW-1:0] s6_nmag [NLane];
  logic s6_nneg [NLane];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = NumW'(s5_cof[c]) <<< (2 * FracB);
    end
    num[3] = NumW'(s5_tsum) <<< FracB;
  end

  always_ff @(posedge clk) begin
    s6_row <= s5_row;
    s6_sing <= (s5_det == '0);
    s6_dneg <= s5_det[DetW-1];
    s6_dmag <= s5_det[DetW-1] ? $unsigned(-s5_det) : $unsigned(s5_det);
    for (int l = 0; l < NLane; l++) begin
      s6_nneg[l] <= num[l][NumW-1];
      s6_nmag[l] <= num[l][NumW-1] ? $unsigned(-num[l]) : $unsigned(num[l]);
    end
  end

  // Divide pipeline. Entry 0 is the setup stage: when the upper numerator bits
  // already reach the divisor the quotient is at least 2^32 and saturates;
  // otherwise they form the starting remainder, and each later stage brings
  // down one low numerator bit.
  logic dv_valid [QuoW+1];
  logic [RowW-1:0] dv_row [QuoW+1];
  logic dv_sing [QuoW+1];
  logic [DetW-1:0] dv_d [QuoW+1];
  logic [DetW-1:0] dv_rem [QuoW+1][NLane];
  logic [QuoW-1:0] dv_nlo [QuoW+1][NLane];
  logic [QuoW-1:0] dv_q [QuoW+1][NLane];
  logic dv_neg [QuoW+1][NLane];
  logic dv_ovf [QuoW+1][NLane];

  logic [NumW-1:0] nhi [NLane];
  logic [DetW:0] trial [QuoW][NLane];

  always_comb begin
    for (int l = 0; l < NLane; l++) begin
      nhi[l] = s6_nmag[l] >> QuoW;
    end
    for (int i = 0; i < QuoW; i++) begin
      for (int l = 0; l < NLane; l++) begin
        trial[i][l] = {dv_rem[i][l], dv_nlo[i][l][QuoW-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_row[0] <= s6_row;
    dv_sing[0] <= s6_sing;
    dv_d[0] <= s6_dmag;
    for (int l = 0; l < NLane; l++) begin
      dv_ovf[0][l] <= (nhi[l] >= NumW'(s6_dmag));
      dv_rem[0][l] <= nhi[l][DetW-1:0];
      dv_nlo[0][l] <= s6_nmag[l][QuoW-1:0];
      dv_q[0][l] <= '0;
      dv_neg[0][l] <= s6_nneg[l] ^ s6_dneg;
    end
    for (int i = 0; i < QuoW; i++) begin
      dv_row[i+1] <= dv_row[i];
      dv_sing[i+1] <= dv_sing[i];
      dv_d[i+1] <= dv_d[i];
      for (int l = 0; l < NLane; l++) begin
        dv_ovf[i+1][l] <= dv_ovf[i][l];
        dv_neg[i+1][l] <= dv_neg[i][l];
        dv_nlo[i+1][l] <= dv_nlo[i][l] << 1;
        if (trial[i][l] >= {1'b0, dv_d[i]}) begin
          dv_rem[i+1][l] <= DetW'(trial[i][l] - {1'b0, dv_d[i]});
          dv_q[i+1][l] <= {dv_q[i][l][QuoW-2:0], 1'b1};
        end else begin
          dv_rem[i+1][l] <= trial[i][l][DetW-1:0];
          dv_q[i+1][l] <= {dv_q[i][l][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      for (int i = 0; i <= QuoW; i++) begin
        dv_valid[i] <= 1'b0;
      end
      valid <= 1'b0;
    end else begin
      s1_valid <= seq_active;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      dv_valid[0] <= s6_valid;
      for (int i = 0; i < QuoW; i++) begin
        dv_valid[i+1] <= dv_valid[i];
      end
      valid <= dv_valid[QuoW];
    end
  end

  // Output stage: sign, saturation, and the identity for a singular matrix.
  logic [QuoW-1:0] qf [NLane];
  logic [ElemW-1:0] res [NLane];
  logic [ElemW-1:0] col_r [NLane];

  always_comb begin
    for (int l = 0; l < NLane; l++) begin
      qf[l] = dv_q[QuoW][l];
      if (dv_sing[QuoW]) begin
        res[l] = (l < 3 && dv_row[QuoW] == RowW'(l)) ? FixOne : '0;
      end else if (dv_neg[QuoW][l]) begin
        if (dv_ovf[QuoW][l] || (qf[l][QuoW-1] && (qf[l][QuoW-2:0] != '0))) begin
          res[l] = SatMin;
        end else begin
          res[l] = ElemW'(-qf[l]);
        end
      end else begin
        if (dv_ovf[QuoW][l] || qf[l][QuoW-1]) begin
          res[l] = SatMax;
        end else begin
          res[l] = ElemW'(qf[l]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r <= res;
    row_index <= dv_row[QuoW];
    singular <= dv_sing[QuoW];
    last_row <= (dv_row[QuoW] == Row2);
  end

  assign col0 = col_r[0];
  assign col1 = col_r[1];
  assign col2 = col_r[2];
  assign col3 = col_r[3];

  // An accepted matrix always blocks the next cycle.
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("busy not raised after a matrix was taken");

  // The rows of one matrix leave on consecutive cycles.
  assert property (@(posedge clk) disable iff (rst)
    valid && row_index == Row0 |=> valid && row_index == Row1)
    else $error("row 1 did not follow row 0");

  assert property (@(posedge clk) disable iff (rst)
    valid && row_index == Row1 |=> valid && row_index == Row2)
    else $error("row 2 did not follow row 1");

  // The singular flag is the same on all rows of a matrix.
  assert property (@(posedge clk) disable iff (rst)
    valid && row_index != Row2 |=> singular == $past(singular))
    else $error("singular flag changed within a matrix");

  // A singular result carries no translation.
  assert property (@(posedge clk) disable iff (rst) valid && singular |-> col3 == '0)
    else $error("singular result with nonzero translation");

endmodule
